### hdl/bfsh_pkg.sv
// Shared constants, types and the fill-pattern function for the binarize
// and single-hole fill unit. No dependencies.
package bfsh_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int PEND_W      = $clog2(MAX_WIDTH + 2);
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 16;
    localparam int LEVEL_W     = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int MIN_WIDTH   = 3;
    localparam int MIN_HEIGHT  = 3;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = HEIGHT_W'(480);
    localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET = LEVEL_W'(128);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2
    } cfg_index_t;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_DRAIN = 1'b1
    } mode_t;

    // 3x3 window, bit = 3*column + row, column 0 oldest (left), row 0 top
    localparam int WIN_ROWS   = 3;
    localparam int WIN_BITS   = 9;
    localparam int WIN_CENTER = 4;
    typedef logic [WIN_BITS-1:0] window_t;

    localparam window_t FILL_RIGHT = 9'h02F;
    localparam window_t FILL_LEFT  = 9'h1E8;
    localparam window_t FILL_UP    = 9'h1A6;
    localparam window_t FILL_DOWN  = 9'h0CB;

    function automatic logic should_fill(input window_t win);
        return !win[WIN_CENTER]
            && (((win & FILL_RIGHT) == FILL_RIGHT)
             || ((win & FILL_LEFT)  == FILL_LEFT)
             || ((win & FILL_UP)    == FILL_UP)
             || ((win & FILL_DOWN)  == FILL_DOWN));
    endfunction

endpackage

### hdl/binarize_and_fill_single_holes_unit.sv
// Binarize a raster pixel stream and close single-pixel holes in place.
// Depends on bfsh_pkg; holds both line stores as one-bit synchronous memories.
//
// Channel  Dir  Handshake                    Payload
// pixel    in   pixel_valid / pixel_stall    mode, pixel_level
// result   out  result_valid / result_stall  pixel_on, hole_filled, last_of_frame
// cfg      in   cfg_write                    cfg_index, cfg_data
//
// One item per clock while the result channel is not stalled; a result reaches the
// result register through stage 1 (line-store read), then window and fill decision.
// The fill feedback closes through the window register and a held
// upper-line entry that is written back on the next pixel, one write per store.
// Reset clears counters, window and handshake state; line stores are not cleared.
// pixel_stall is high only while a result waits in a full, stalled result register.
module binarize_and_fill_single_holes_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic                                mode,
    input  logic [bfsh_pkg::LEVEL_W-1:0]        pixel_level,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                pixel_on,
    output logic                                hole_filled,
    output logic                                last_of_frame,
    input  logic                                cfg_write,
    input  logic [bfsh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bfsh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int COL_W    = bfsh_pkg::COL_W;
    localparam int PEND_W   = bfsh_pkg::PEND_W;
    localparam int HEIGHT_W = bfsh_pkg::HEIGHT_W;
    localparam int WIN_BITS = bfsh_pkg::WIN_BITS;
    localparam int WIN_ROWS = bfsh_pkg::WIN_ROWS;

    // configuration
    logic [bfsh_pkg::WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0]           height_reg;
    logic [bfsh_pkg::LEVEL_W-1:0]  thr_reg;

    // frame position
    logic [COL_W-1:0]    col_reg;
    logic [HEIGHT_W-1:0] row_reg;
    logic [PEND_W-1:0]   pend_reg;

    // line stores
    logic upper_mem  [bfsh_pkg::MAX_WIDTH];
    logic middle_mem [bfsh_pkg::MAX_WIDTH];
    logic up_a_reg, up_b_reg, mid_a_reg, mid_b_reg;

    // upper-line entry waiting for its fill decision
    logic             held_valid_reg;
    logic [COL_W-1:0] held_addr_reg;
    logic             held_m_reg;

    bfsh_pkg::window_t window_reg;

    // stage 1
    logic             s1_valid_reg;
    logic             s1_drain_reg;
    logic             s1_emit_reg;
    logic             s1_col_zero_reg;
    logic             s1_col_ge2_reg;
    logic             s1_row_ge2_reg;
    logic             s1_bin_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_drain_upper_reg;
    logic             s1_last_reg;
    logic             s1_fwd_hit_reg;
    logic             s1_fwd_bit_reg;

    logic result_valid_reg, pixel_on_reg, hole_filled_reg, last_reg;

    // stage 0 logic
    logic                in_accept;
    logic                is_drain;
    logic [COL_W:0]      weff;
    logic [COL_W-1:0]    wlast;
    logic [PEND_W-1:0]   wplus;
    logic [HEIGHT_W-1:0] heff;
    logic                col_wrap;
    logic [COL_W-1:0]    ic;
    logic [HEIGHT_W:0]   row_pre;
    logic [HEIGHT_W-1:0] ir;
    logic [COL_W:0]      col_inc;
    logic [HEIGHT_W:0]   row_inc;
    logic                col_end, row_end;
    logic [COL_W-1:0]    col_next;
    logic [HEIGHT_W-1:0] row_next;
    logic [PEND_W-1:0]   pend_clamp, pend_dec, mid_diff;
    logic [COL_W-1:0]    mid_addr;
    logic                drain_live, drain_upper, drain_last;
    logic                col_zero, col_ge2, row_ge1, row_ge2, bin;
    logic                emit;

    // stage 1 logic
    logic              out_ready, s1_fire;
    bfsh_pkg::window_t shifted, filled_win;
    logic              fill;
    logic              up_b_fwd;
    logic              pix;
    logic              up_we, up_wdata;
    logic              fwd_hit_next;

    always_comb
    begin
        in_accept = pixel_valid && !pixel_stall;
        is_drain  = (mode == bfsh_pkg::MODE_DRAIN);

        if (width_reg < bfsh_pkg::MIN_WIDTH)
        begin
            weff = (COL_W+1)'(bfsh_pkg::MIN_WIDTH);
        end
        else if (width_reg > bfsh_pkg::MAX_WIDTH)
        begin
            weff = (COL_W+1)'(bfsh_pkg::MAX_WIDTH);
        end
        else
        begin
            weff = (COL_W+1)'(width_reg);
        end
        wlast = COL_W'(weff - (COL_W+1)'(1));
        wplus = PEND_W'(weff) + PEND_W'(1);
        heff  = (height_reg < bfsh_pkg::MIN_HEIGHT) ? HEIGHT_W'(bfsh_pkg::MIN_HEIGHT)
                                                    : height_reg;

        // wrap counters left beyond a smaller geometry
        col_wrap = ({1'b0, col_reg} >= weff);
        ic       = col_wrap ? '0 : col_reg;
        row_pre  = col_wrap ? ({1'b0, row_reg} + (HEIGHT_W+1)'(1)) : {1'b0, row_reg};
        ir       = (row_pre >= {1'b0, heff}) ? '0 : row_pre[HEIGHT_W-1:0];

        col_inc  = {1'b0, ic} + (COL_W+1)'(1);
        row_inc  = {1'b0, ir} + (HEIGHT_W+1)'(1);
        col_end  = (col_inc >= weff);
        row_end  = (row_inc >= {1'b0, heff});
        col_next = col_end ? '0 : col_inc[COL_W-1:0];
        row_next = col_end ? (row_end ? '0 : row_inc[HEIGHT_W-1:0]) : ir;

        pend_clamp  = (pend_reg > wplus) ? wplus : pend_reg;
        pend_dec    = pend_clamp - PEND_W'(1);
        mid_diff    = PEND_W'(weff) - pend_clamp;
        mid_addr    = mid_diff[COL_W-1:0];
        drain_live  = (pend_reg != '0);
        drain_upper = (pend_clamp == wplus);
        drain_last  = (pend_dec == '0);

        col_zero = (ic == '0);
        col_ge2  = (ic[COL_W-1:1] != '0);
        row_ge1  = (ir != '0);
        row_ge2  = (ir[HEIGHT_W-1:1] != '0);
        bin      = (pixel_level > thr_reg);
        emit     = is_drain ? drain_live
                            : ((!col_zero && row_ge1) || (col_zero && row_ge2));
    end

    always_comb
    begin
        out_ready   = !result_valid_reg || !result_stall;
        s1_fire     = s1_valid_reg && (!s1_emit_reg || out_ready);
        pixel_stall = s1_valid_reg && !s1_fire;

        shifted = {s1_bin_reg, mid_a_reg, up_a_reg, window_reg[WIN_BITS-1:WIN_ROWS]};
        fill    = !s1_drain_reg && s1_col_ge2_reg && s1_row_ge2_reg
               && bfsh_pkg::should_fill(shifted);
        filled_win = shifted;
        filled_win[bfsh_pkg::WIN_CENTER] = shifted[bfsh_pkg::WIN_CENTER] | fill;

        // newest copy of the right-border upper entry
        if (held_valid_reg && (held_addr_reg == wlast))
        begin
            up_b_fwd = held_m_reg;
        end
        else if (s1_fwd_hit_reg)
        begin
            up_b_fwd = s1_fwd_bit_reg;
        end
        else
        begin
            up_b_fwd = up_b_reg;
        end

        if (s1_drain_reg)
        begin
            pix = s1_drain_upper_reg ? up_b_fwd : mid_b_reg;
        end
        else if (s1_col_zero_reg)
        begin
            pix = up_b_fwd;
        end
        else
        begin
            pix = filled_win[bfsh_pkg::WIN_CENTER];
        end

        // retire the held entry, closed if the fill decision hit it
        up_we        = s1_fire && !s1_drain_reg && held_valid_reg;
        up_wdata     = held_m_reg | fill;
        fwd_hit_next = up_we && (held_addr_reg == wlast);
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            up_a_reg <= upper_mem[ic];
            up_b_reg <= upper_mem[wlast];
        end
        if (up_we)
        begin
            upper_mem[held_addr_reg] <= up_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mid_a_reg <= middle_mem[ic];
            mid_b_reg <= middle_mem[mid_addr];
        end
        if (in_accept && !is_drain)
        begin
            middle_mem[ic] <= bin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= bfsh_pkg::WIDTH_RESET;
            height_reg       <= bfsh_pkg::HEIGHT_RESET;
            thr_reg          <= bfsh_pkg::THRESHOLD_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            pend_reg         <= '0;
            held_valid_reg   <= 1'b0;
            window_reg       <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    bfsh_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[bfsh_pkg::WIDTH_W-1:0];
                    bfsh_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                    bfsh_pkg::CFG_THRESHOLD:    thr_reg    <= cfg_data[bfsh_pkg::LEVEL_W-1:0];
                    default:                    ;
                endcase
            end

            if (in_accept)
            begin
                if (is_drain)
                begin
                    if (drain_live)
                    begin
                        pend_reg <= pend_dec;
                    end
                end
                else
                begin
                    col_reg  <= col_next;
                    row_reg  <= row_next;
                    pend_reg <= (col_end && row_end) ? wplus : '0;
                end
            end

            if (s1_fire && !s1_drain_reg)
            begin
                held_valid_reg <= 1'b1;
                window_reg     <= filled_win;
            end

            s1_valid_reg <= in_accept || (s1_valid_reg && !s1_fire);

            if (s1_fire && s1_emit_reg)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_drain_reg       <= is_drain;
            s1_emit_reg        <= emit;
            s1_col_zero_reg    <= col_zero;
            s1_col_ge2_reg     <= col_ge2;
            s1_row_ge2_reg     <= row_ge2;
            s1_bin_reg         <= bin;
            s1_col_reg         <= ic;
            s1_drain_upper_reg <= drain_upper;
            s1_last_reg        <= drain_last;
            // catch the upper write that lands in the same cycle as this read
            s1_fwd_hit_reg     <= fwd_hit_next;
            s1_fwd_bit_reg     <= up_wdata;
        end

        if (s1_fire && !s1_drain_reg)
        begin
            held_addr_reg <= s1_col_reg;
            held_m_reg    <= mid_a_reg;
        end

        if (s1_fire && s1_emit_reg)
        begin
            pixel_on_reg    <= pix;
            hole_filled_reg <= fill;
            last_reg        <= s1_drain_reg && s1_last_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign pixel_on      = pixel_on_reg;
    assign hole_filled   = hole_filled_reg;
    assign last_of_frame = last_reg;

endmodule

### hdl/bfsh_checker.sv
// Port-level checks for binarize_and_fill_single_holes_unit, bound to the top.
// No package dependencies.
module bfsh_checker (
    input logic clk,
    input logic rst_n,
    input logic pixel_stall,
    input logic result_valid,
    input logic result_stall,
    input logic pixel_on,
    input logic hole_filled,
    input logic last_of_frame
);

    // a stalled result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(pixel_on)
            && $stable(hole_filled) && $stable(last_of_frame))
    else $error("result changed while stalled");

    // input backpressure only comes from a blocked result register
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> result_valid && result_stall)
    else $error("pixel_stall without a stalled result");

    // a filled pixel is on and never the drained last pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && hole_filled |-> pixel_on && !last_of_frame)
    else $error("hole_filled on an off or last pixel");

endmodule

bind binarize_and_fill_single_holes_unit bfsh_checker u_bfsh_checker (.*);
